// ===== sv/jcl_pkg.sv =====
package jcl_pkg;

    // Address field layout
    localparam int ADDR_W  = 16;
    localparam int RANK_W  = 6;
    localparam int ETA_W   = 3;
    localparam int PHI_W   = 5;
    localparam int EFF_W   = 4;   // effective eta, 0..14
    localparam int RANK_LO = 0;
    localparam int ETA_LO  = 6;
    localparam int PHI_LO  = 9;
    localparam int FWD_BIT = 14;
    localparam int TAU_BIT = 15;

    // Forward jets are offset by this many eta bins
    localparam logic [EFF_W-1:0] FWD_ETA_OFS = 4'd7;

    // Cut register widths
    localparam int NUM_CUTS_W = 2;
    localparam int TYPE_W     = 3;
    localparam int FIRST_W    = 6;
    localparam int SECOND_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Register map: index 0 is num_cuts, then three registers per slot
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CUTS = 3'd0;
    localparam int REG_CUT_BASE = 1;
    localparam int REG_PER_SLOT = 3;
    localparam int FLD_TYPE     = 0;
    localparam int FLD_FIRST    = 1;
    localparam int FLD_SECOND   = 2;
    localparam int REG_SLOTS    = 2;  // slots backed by registers
    localparam logic [NUM_CUTS_W-1:0] NUM_CUTS_RST = 2'd1;

    // Cut type codes; 6 and 7 are illegal
    localparam logic [TYPE_W-1:0] CUT_NULL     = 3'd0;
    localparam logic [TYPE_W-1:0] CUT_MIN_RANK = 3'd1;
    localparam logic [TYPE_W-1:0] CUT_MAX_RANK = 3'd2;
    localparam logic [TYPE_W-1:0] CUT_CEN_ETA  = 3'd3;
    localparam logic [TYPE_W-1:0] CUT_FWD_ETA  = 3'd4;
    localparam logic [TYPE_W-1:0] CUT_PHI_WIN  = 3'd5;

    typedef struct packed {
        logic [TYPE_W-1:0]   cut_type;
        logic [FIRST_W-1:0]  first;
        logic [SECOND_W-1:0] second;
    } t_cut;

    localparam t_cut CUT_RESET = '{cut_type: CUT_NULL, first: '0, second: '0};

    // Per-slot verdict
    typedef struct packed {
        logic holds;
        logic legal;
    } t_cut_res;

endpackage

// ===== sv/jcl_in_if.sv =====
interface jcl_in_if import jcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] lut_address;

    modport source (output valid, output lut_address, input ready);
    modport sink   (input valid, input lut_address, output ready);
endinterface

// ===== sv/jcl_out_if.sv =====
interface jcl_out_if import jcl_pkg::*; ();
    logic valid;
    logic ready;
    logic passes;
    logic table_bit;
    logic setup_valid;

    modport source (output valid, output passes, output table_bit, output setup_valid,
                    input ready);
    modport sink   (input valid, input passes, input table_bit, input setup_valid,
                    output ready);
endinterface

// ===== sv/jet_cut_lut_evaluator.sv =====
// Jet cut lookup evaluator. Each input word is a 16-bit jet table address (rank,
// eta, phi, forward and tau flags); each output word carries passes, table_bit
// (its inverse) and setup_valid for the cuts currently programmed. One word is
// accepted per clock while the output is not stalled by back-pressure; a word
// passes through the address register and then the result register, with the cut compares
// in between. Cut registers are written through the plain write port and must
// only change while no word is in flight.
module jet_cut_lut_evaluator import jcl_pkg::*; #(
    parameter int CUT_SLOTS = 2,
    parameter int PHI_BINS  = 18,
    parameter int ETA_BINS  = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jcl_in_if.sink                i_in,
    jcl_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [PHI_W:0] PhiLim = (PHI_W + 1)'(PHI_BINS);

    t_cut                 cuts [CUT_SLOTS];
    logic [CUT_SLOTS-1:0] apply;
    t_cut_res             res  [CUT_SLOTS];
    logic [CUT_SLOTS-1:0] ok_holds;
    logic [CUT_SLOTS-1:0] ok_legal;

    logic                 r_in_vld;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_out_vld;
    logic                 r_passes;
    logic                 r_setup_valid;
    logic                 n_passes;
    logic                 n_setup_valid;

    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s1_fire;

    logic [RANK_W-1:0]    rank;
    logic [ETA_W-1:0]     eta;
    logic [PHI_W-1:0]     phi;
    logic                 fwd;
    logic                 tau;
    logic [EFF_W-1:0]     eff_eta;
    logic                 jet_ok;

    jcl_cfg_regs #(
        .CUT_SLOTS (CUT_SLOTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cuts      (cuts),
        .o_apply     (apply)
    );

    // Pipeline handshake
    assign s2_ready   = !r_out_vld || o_out.ready;
    assign s1_ready   = !r_in_vld || s2_ready;
    assign s1_fire    = r_in_vld && s2_ready;
    assign i_in.ready = s1_ready;

    // Address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s1_ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_addr <= i_in.lut_address;
        end
    end

    // Address unpack
    assign rank    = r_addr[RANK_LO +: RANK_W];
    assign eta     = r_addr[ETA_LO +: ETA_W];
    assign phi     = r_addr[PHI_LO +: PHI_W];
    assign fwd     = r_addr[FWD_BIT];
    assign tau     = r_addr[TAU_BIT];
    assign eff_eta = {1'b0, eta} + (fwd ? FWD_ETA_OFS : '0);
    assign jet_ok  = ({1'b0, phi} < PhiLim) && !(fwd && tau) && (rank != '0);

    // One checker per slot
    for (genvar s = 0; s < CUT_SLOTS; s++) begin : g_chk
        jcl_cut_check #(
            .PHI_BINS (PHI_BINS),
            .ETA_BINS (ETA_BINS)
        ) u_chk (
            .i_cut     (cuts[s]),
            .i_rank    (rank),
            .i_eff_eta (eff_eta),
            .i_phi     (phi),
            .o_res     (res[s])
        );
        assign ok_holds[s] = res[s].holds || !apply[s];
        assign ok_legal[s] = res[s].legal || !apply[s];
    end

    assign n_passes      = jet_ok && (&ok_holds);
    assign n_setup_valid = &ok_legal;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_passes      <= n_passes;
            r_setup_valid <= n_setup_valid;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.passes      = r_passes;
    assign o_out.table_bit   = !r_passes;
    assign o_out.setup_valid = r_setup_valid;

    // A word taken in reaches the address register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_vld)
        else $error("accepted word lost at address register");

    // A word leaving stage one lands in the result register
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_vld)
        else $error("word lost between stages");

    // A held result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_passes)))
        else $error("stalled result overwritten");

    // A passing word had nonzero rank, a legal phi and not both fwd and tau set
    a_pass_jet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !jet_ok) |=> !r_passes)
        else $error("invalid jet reported as passing");

endmodule

// ===== sv/jcl_cfg_regs.sv =====
module jcl_cfg_regs import jcl_pkg::*; #(
    parameter int CUT_SLOTS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cut                  o_cuts [CUT_SLOTS],
    output logic [CUT_SLOTS-1:0]  o_apply
);

    logic [NUM_CUTS_W-1:0] r_num_cuts;

    // Number of applied slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cuts <= NUM_CUTS_RST;
        end else if (i_cfg_we && i_cfg_index == REG_NUM_CUTS) begin
            r_num_cuts <= i_cfg_data[NUM_CUTS_W-1:0];
        end
    end

    for (genvar s = 0; s < CUT_SLOTS; s++) begin : g_slot
        // Slot s is applied when num_cuts exceeds s; saturation is implicit
        assign o_apply[s] = ({1'b0, r_num_cuts} > (NUM_CUTS_W + 1)'(s));

        if (s < REG_SLOTS) begin : g_reg
            localparam logic [CFG_IDX_W-1:0] TypeIdx =
                CFG_IDX_W'(REG_CUT_BASE + REG_PER_SLOT * s + FLD_TYPE);
            localparam logic [CFG_IDX_W-1:0] FirstIdx =
                CFG_IDX_W'(REG_CUT_BASE + REG_PER_SLOT * s + FLD_FIRST);
            localparam logic [CFG_IDX_W-1:0] SecondIdx =
                CFG_IDX_W'(REG_CUT_BASE + REG_PER_SLOT * s + FLD_SECOND);

            t_cut r_cut;

            // Field writes, masked to register width
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cut <= CUT_RESET;
                end else if (i_cfg_we) begin
                    if (i_cfg_index == TypeIdx) begin
                        r_cut.cut_type <= i_cfg_data[TYPE_W-1:0];
                    end
                    if (i_cfg_index == FirstIdx) begin
                        r_cut.first <= i_cfg_data[FIRST_W-1:0];
                    end
                    if (i_cfg_index == SecondIdx) begin
                        r_cut.second <= i_cfg_data[SECOND_W-1:0];
                    end
                end
            end

            assign o_cuts[s] = r_cut;
        end else begin : g_null
            // No registers behind this slot: permanently a null cut
            assign o_cuts[s] = CUT_RESET;
        end
    end

endmodule

// ===== sv/jcl_cut_check.sv =====
module jcl_cut_check import jcl_pkg::*; #(
    parameter int PHI_BINS = 18,
    parameter int ETA_BINS = 22
) (
    input  t_cut               i_cut,
    input  logic [RANK_W-1:0]  i_rank,
    input  logic [EFF_W-1:0]   i_eff_eta,
    input  logic [PHI_W-1:0]   i_phi,
    output t_cut_res           o_res
);

    localparam logic [FIRST_W:0] PhiLim = (FIRST_W + 1)'(PHI_BINS);
    localparam logic [FIRST_W:0] EtaLim = (FIRST_W + 1)'(ETA_BINS / 2);

    logic [FIRST_W-1:0] a;
    logic [FIRST_W-1:0] b;
    logic [FIRST_W-1:0] eta_x;
    logic [FIRST_W-1:0] phi_x;
    logic               phi_in;

    assign a     = i_cut.first;
    assign b     = {1'b0, i_cut.second};
    assign eta_x = {2'b00, i_eff_eta};
    assign phi_x = {1'b0, i_phi};

    // Phi window, wraps when end is not above start
    always_comb begin
        if (b > a) begin
            phi_in = (phi_x >= a) && (phi_x <= b);
        end else begin
            phi_in = (phi_x >= a) || (phi_x <= b);
        end
    end

    // Cut verdict and legality
    always_comb begin
        o_res = '0;
        case (i_cut.cut_type)
            CUT_NULL: begin
                o_res.holds = 1'b0;
                o_res.legal = 1'b1;
            end
            CUT_MIN_RANK: begin
                o_res.holds = (i_rank >= a);
                o_res.legal = 1'b1;   // any 6-bit rank value fits
            end
            CUT_MAX_RANK: begin
                o_res.holds = (i_rank <= a);
                o_res.legal = 1'b1;
            end
            CUT_CEN_ETA: begin
                o_res.holds = (eta_x <= a);
                o_res.legal = ({1'b0, a} < EtaLim);
            end
            CUT_FWD_ETA: begin
                o_res.holds = (eta_x >= a);
                o_res.legal = ({1'b0, a} < EtaLim);
            end
            CUT_PHI_WIN: begin
                o_res.holds = phi_in;
                o_res.legal = ({1'b0, a} < PhiLim) && ({1'b0, b} < PhiLim);
            end
            default: begin
                o_res.holds = 1'b0;
                o_res.legal = 1'b0;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_jet_cut_lut_evaluator.sv =====
`timescale 1ns / 100ps

module tb_jet_cut_lut_evaluator;
    import jcl_pkg::*;

    localparam int TB_CUT_SLOTS = 2;
    localparam int TB_PHI_BINS  = 18;
    localparam int TB_ETA_BINS  = 22;

    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 50;
    localparam int RAND_PHASES  = 13;

    // Index past the last cut register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    // Illegal cut type codes
    localparam logic [TYPE_W-1:0] CUT_BAD_LO = 3'd6;
    localparam logic [TYPE_W-1:0] CUT_BAD_HI = 3'd7;

    typedef struct packed {
        logic passes;
        logic table_bit;
        logic setup_valid;
    } t_verdict;

    // Shadow copy of the cut setup plus the words still owed by the block
    class verdict_board;
        t_cut            cuts [TB_CUT_SLOTS];
        logic [NUM_CUTS_W-1:0] cut_count;
        t_verdict        owed [$];
        int              fails;
        int              words_in;
        int              checked;
        int              pass_seen;
        int              illegal_seen;

        function new();
            foreach (cuts[s]) cuts[s] = CUT_RESET;
            cut_count    = NUM_CUTS_RST;
            fails        = 0;
            words_in     = 0;
            checked      = 0;
            pass_seen    = 0;
            illegal_seen = 0;
        endfunction

        // Register write, masked to each register's width
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int slot;
            int fld;
            if (idx == REG_NUM_CUTS) begin
                cut_count = data[NUM_CUTS_W-1:0];
            end else if (int'(idx) < REG_CUT_BASE + REG_SLOTS * REG_PER_SLOT) begin
                slot = (int'(idx) - REG_CUT_BASE) / REG_PER_SLOT;
                fld  = (int'(idx) - REG_CUT_BASE) % REG_PER_SLOT;
                if (slot < TB_CUT_SLOTS) begin
                    case (fld)
                        FLD_TYPE:  cuts[slot].cut_type = data[TYPE_W-1:0];
                        FLD_FIRST: cuts[slot].first    = data[FIRST_W-1:0];
                        default:   cuts[slot].second   = data[SECOND_W-1:0];
                    endcase
                end
            end
        endfunction

        function logic cut_is_legal(t_cut c);
            case (c.cut_type)
                CUT_MIN_RANK, CUT_MAX_RANK: return int'(c.first) < (1 << RANK_W);
                CUT_CEN_ETA, CUT_FWD_ETA:   return int'(c.first) < TB_ETA_BINS / 2;
                CUT_PHI_WIN: return int'(c.first) < TB_PHI_BINS && int'(c.second) < TB_PHI_BINS;
                CUT_NULL:    return 1'b1;
                default:     return 1'b0;
            endcase
        endfunction

        function logic cut_holds(t_cut c, logic [RANK_W-1:0] rank, logic [EFF_W-1:0] eff,
                                 logic [PHI_W-1:0] phi);
            case (c.cut_type)
                CUT_MIN_RANK: return rank >= c.first;
                CUT_MAX_RANK: return rank <= c.first;
                CUT_CEN_ETA:  return eff <= c.first;
                CUT_FWD_ETA:  return eff >= c.first;
                CUT_PHI_WIN: begin
                    // window wraps around when the end is not above the start
                    if (c.second > c.first)
                        return phi >= c.first && phi <= c.second;
                    return phi >= c.first || phi <= c.second;
                end
                default:      return 1'b0;
            endcase
        endfunction

        function t_verdict judge_address(logic [ADDR_W-1:0] addr);
            logic [RANK_W-1:0] rank;
            logic [ETA_W-1:0]  eta;
            logic [PHI_W-1:0]  phi;
            logic              fwd;
            logic              tau;
            logic [EFF_W-1:0]  eff;
            int                applied;
            logic              ok;
            logic              legal;
            t_verdict          v;
            rank = addr[RANK_LO +: RANK_W];
            eta  = addr[ETA_LO +: ETA_W];
            phi  = addr[PHI_LO +: PHI_W];
            fwd  = addr[FWD_BIT];
            tau  = addr[TAU_BIT];
            eff  = EFF_W'(eta) + (fwd ? FWD_ETA_OFS : '0);
            // extra cut count saturates at the slots that exist
            applied = (int'(cut_count) > TB_CUT_SLOTS) ? TB_CUT_SLOTS : int'(cut_count);
            legal = 1'b1;
            for (int s = 0; s < applied; s++)
                legal = legal && cut_is_legal(cuts[s]);
            ok = (int'(phi) < TB_PHI_BINS) && !(fwd && tau) && (rank != '0);
            for (int s = 0; s < applied; s++)
                if (ok) ok = cut_holds(cuts[s], rank, eff, phi);
            v.passes      = ok;
            v.table_bit   = !ok;
            v.setup_valid = legal;
            return v;
        endfunction

        function void note_address(logic [ADDR_W-1:0] addr);
            owed.push_back(judge_address(addr));
            words_in++;
        endfunction

        function void compare_field(string field, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
                fails++;
            end
        endfunction

        function void check_verdict(logic passes, logic table_bit, logic setup_valid);
            t_verdict want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %b%b%b",
                         $time, passes, table_bit, setup_valid);
                fails++;
                return;
            end
            want = owed.pop_front();
            compare_field("passes", want.passes, passes);
            compare_field("table_bit", want.table_bit, table_bit);
            compare_field("setup_valid", want.setup_valid, setup_valid);
            checked++;
            if (want.passes) pass_seen++;
            if (!want.setup_valid) illegal_seen++;
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jcl_in_if  in_ch ();
    jcl_out_if out_ch ();

    verdict_board board;
    int           sender_idle_pct;
    int           receiver_idle_pct;
    int           cycle_count = 0;
    int           setups = 0;

    jet_cut_lut_evaluator #(
        .CUT_SLOTS (TB_CUT_SLOTS),
        .PHI_BINS  (TB_PHI_BINS),
        .ETA_BINS  (TB_ETA_BINS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Note accepted words first, then check any word leaving the block
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready)
                board.note_address(in_ch.lut_address);
            if (out_ch.valid && out_ch.ready)
                board.check_verdict(out_ch.passes, out_ch.table_bit, out_ch.setup_valid);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** jet_cut_lut_evaluator: FAILED **");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] make_address(logic [RANK_W-1:0] rank,
            logic [ETA_W-1:0] eta, logic [PHI_W-1:0] phi, logic fwd, logic tau);
        logic [ADDR_W-1:0] a;
        a = '0;
        a[RANK_LO +: RANK_W] = rank;
        a[ETA_LO +: ETA_W]   = eta;
        a[PHI_LO +: PHI_W]   = phi;
        a[FWD_BIT]           = fwd;
        a[TAU_BIT]           = tau;
        return a;
    endfunction

    // Mostly well-formed jets so the cut logic gets exercised; the rest is raw noise
    function automatic logic [ADDR_W-1:0] random_address();
        int flags;
        if ($urandom_range(0, 99) < 25)
            return ADDR_W'($urandom);
        flags = $urandom_range(0, 2);
        return make_address(RANK_W'($urandom_range(1, 63)), ETA_W'($urandom),
                            PHI_W'($urandom_range(0, TB_PHI_BINS - 1)), flags == 1, flags == 2);
    endfunction

    function automatic logic [CFG_IDX_W-1:0] reg_index(int slot, int fld);
        return CFG_IDX_W'(REG_CUT_BASE + slot * REG_PER_SLOT + fld);
    endfunction

    // Write every register back to back, plus one write to the unmapped index
    task automatic program_cuts(input logic [CFG_DATA_W-1:0] n,
                                input logic [CFG_DATA_W-1:0] t0, f0, s0,
                                input logic [CFG_DATA_W-1:0] t1, f1, s1);
        logic [CFG_DATA_W-1:0] vals [0:(1 << CFG_IDX_W) - 1];
        vals[REG_NUM_CUTS]           = n;
        vals[reg_index(0, FLD_TYPE)]   = t0;
        vals[reg_index(0, FLD_FIRST)]  = f0;
        vals[reg_index(0, FLD_SECOND)] = s0;
        vals[reg_index(1, FLD_TYPE)]   = t1;
        vals[reg_index(1, FLD_FIRST)]  = f1;
        vals[reg_index(1, FLD_SECOND)] = s1;
        vals[REG_UNMAPPED]           = CFG_DATA_W'($urandom);
        for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            board.apply_write(CFG_IDX_W'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    // Random cut slot; unused upper data bits are filled with noise
    task automatic pick_cut(output logic [CFG_DATA_W-1:0] t, f, s);
        int               roll;
        logic [TYPE_W-1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            kind = CUT_NULL;
        else if (roll < 16)
            kind = $urandom_range(0, 1) ? CUT_BAD_HI : CUT_BAD_LO;
        else
            kind = TYPE_W'($urandom_range(CUT_MIN_RANK, CUT_PHI_WIN));
        t = {3'($urandom), kind};
        case (kind)
            CUT_CEN_ETA, CUT_FWD_ETA: f = 6'($urandom_range(0, 15));
            CUT_PHI_WIN:              f = 6'($urandom_range(0, 19));
            default:                  f = 6'($urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 9) == 0) f = 6'($urandom);
        s = {1'($urandom), 5'($urandom_range(0, 19))};
        if ($urandom_range(0, 9) == 0) s[SECOND_W-1:0] = 5'($urandom);
    endtask

    task automatic random_setup();
        int                    roll;
        logic [NUM_CUTS_W-1:0] n;
        logic [CFG_DATA_W-1:0] t0, f0, s0, t1, f1, s1;
        roll = $urandom_range(0, 99);
        n = (roll < 10) ? 2'd0 : (roll < 40) ? 2'd1 : (roll < 85) ? 2'd2 : 2'd3;
        pick_cut(t0, f0, s0);
        pick_cut(t1, f1, s1);
        program_cuts({4'($urandom), n}, t0, f0, s0, t1, f1, s1);
    endtask

    // Present one word, with random gaps ahead of it, and hold it until taken
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.lut_address <= addr;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.lut_address <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_rst_n           <= 1'b0;
        board             = new();
        sender_idle_pct   = 16;
        receiver_idle_pct = 64;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setup: single null cut, nothing passes
        send_address(make_address(6'd5, 3'd0, 5'd0, 1'b0, 1'b0));
        send_address(make_address(6'd0, 3'd0, 5'd0, 1'b0, 1'b0));
        wait_idle();

        // No cuts: only the address checks matter
        program_cuts(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_address(make_address(6'd1, 3'd0, 5'd0, 1'b0, 1'b0));
        send_address(make_address(6'd63, 3'd7, 5'd17, 1'b1, 1'b0));
        send_address(make_address(6'd10, 3'd3, 5'd18, 1'b0, 1'b0));
        send_address(make_address(6'd10, 3'd3, 5'd31, 1'b0, 1'b0));
        send_address(make_address(6'd10, 3'd3, 5'd4, 1'b1, 1'b1));
        send_address(make_address(6'd10, 3'd3, 5'd4, 1'b0, 1'b1));
        send_address(make_address(6'd0, 3'd2, 5'd2, 1'b0, 1'b0));
        wait_idle();

        // Rank window 32..40
        program_cuts(6'd2, CFG_DATA_W'(CUT_MIN_RANK), 6'd32, 6'd0,
                     CFG_DATA_W'(CUT_MAX_RANK), 6'd40, 6'd0);
        send_address(make_address(6'd31, 3'd1, 5'd1, 1'b0, 1'b0));
        send_address(make_address(6'd32, 3'd1, 5'd1, 1'b0, 1'b0));
        send_address(make_address(6'd40, 3'd1, 5'd1, 1'b0, 1'b0));
        send_address(make_address(6'd41, 3'd1, 5'd1, 1'b0, 1'b0));
        wait_idle();

        // Effective eta window 3..10, forward jets shifted up by seven
        program_cuts(6'd2, CFG_DATA_W'(CUT_CEN_ETA), 6'd10, 6'd0,
                     CFG_DATA_W'(CUT_FWD_ETA), 6'd3, 6'd0);
        send_address(make_address(6'd5, 3'd2, 5'd0, 1'b0, 1'b0));
        send_address(make_address(6'd5, 3'd3, 5'd0, 1'b0, 1'b0));
        send_address(make_address(6'd5, 3'd4, 5'd0, 1'b1, 1'b0));
        wait_idle();

        // Too many cuts, wrapping phi window, illegal second slot
        program_cuts(6'd3, CFG_DATA_W'(CUT_PHI_WIN), 6'd16, 6'd3,
                     CFG_DATA_W'(CUT_BAD_LO), 6'd0, 6'd0);
        send_address(make_address(6'd5, 3'd0, 5'd17, 1'b0, 1'b0));
        send_address(make_address(6'd5, 3'd0, 5'd10, 1'b0, 1'b0));
        wait_idle();

        // Plain phi window 2..5; illegal slot one is not applied
        program_cuts(6'd1, CFG_DATA_W'(CUT_PHI_WIN), 6'd2, 6'd5,
                     CFG_DATA_W'(CUT_BAD_HI), 6'd63, 6'd31);
        send_address(make_address(6'd9, 3'd0, 5'd1, 1'b0, 1'b0));
        send_address(make_address(6'd9, 3'd0, 5'd2, 1'b0, 1'b0));
        send_address(make_address(6'd9, 3'd0, 5'd5, 1'b0, 1'b0));
        send_address(make_address(6'd9, 3'd0, 5'd6, 1'b0, 1'b0));
        wait_idle();

        // Random phases; the first two use all-zero and all-one register data
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < 5) begin
                sender_idle_pct   = 16;
                receiver_idle_pct = 64;
            end else if (ph < 9) begin
                sender_idle_pct   = 64;
                receiver_idle_pct = 16;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (ph)
                0:       program_cuts('0, '0, '0, '0, '0, '0, '0);
                1:       program_cuts('1, '1, '1, '1, '1, '1, '1);
                default: random_setup();
            endcase
            for (int k = 0; k < PHASE_WORDS; k++)
                send_address(random_address());
            wait_idle();
        end

        board.fails += board.pending();
        $display("Covered %0d address words over %0d cut setups, with and without idling.",
                 board.words_in, setups);
        $display("Results checked: %0d, passing jets: %0d, words under an illegal setup: %0d.",
                 board.checked, board.pass_seen, board.illegal_seen);
        if (board.fails == 0) begin
            $display("** jet_cut_lut_evaluator: PASSED **");
        end else begin
            $display("** jet_cut_lut_evaluator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/jcl_pkg.sv
sv/jcl_in_if.sv
sv/jcl_out_if.sv
sv/jcl_cfg_regs.sv
sv/jcl_cut_check.sv
sv/jet_cut_lut_evaluator.sv
tb/sv/tb_jet_cut_lut_evaluator.sv
